FILE: rtl/kvl_pkg.sv
package kvl_pkg;

   localparam int MAX_KEYS  = 64;
   localparam int KEY_IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);

   // dividend is |query - t0| scaled by 2^16
   localparam int DVD_W     = 49;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   localparam logic [1:0] CSR_KEY_COUNT = 2'd0;
   localparam logic [1:0] CSR_MIN_RANGE = 2'd1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } kvl_key_type;

   typedef struct packed {
      logic        valid;
      logic        first;
      logic        found;
      kvl_key_type ki;
      kvl_key_type kj;
   } kvl_tok_type;

endpackage

FILE: rtl/keyframe_vec3_lerp.sv
// keyframe_vec3_lerp: keyframe table with linear xyz blend, signed Q16.16
//
// request channel (req_valid / req_stall): a word is taken when valid is high
// and stall is low. req_type write stores one keyframe at req_key_slot and
// gives no response. req_type query samples the table at req_query_time and
// gives exactly one response word.
// response channel (rsp_valid / rsp_stall): out_x/y/z plus saturated flag.
// csr port: csr_wr_en writes key_count (index 0) or min_range (index 1); the user
// must write only while the block is idle, and the block itself does not enforce it.
//
// query steps: the segment search (a token walks the row of key cells, one
// cell per cycle), the bit-serial factor divide (load plus 49 steps), the
// three shared-multiplier blends, then the output register.
// short segments, single-key and empty tables skip divide and blend.
// one query in flight at a time: requests stall until it ends; a write leaves it idle.
// reset clears control state, key_count to 0 and min_range to 7; table
// contents are undefined until written. a stalled response holds; the next
// request is still taken while it waits, and a finished query waits for it.
module keyframe_vec3_lerp
   import kvl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [5:0]  req_key_slot,
   input  logic [31:0] req_key_time,
   input  logic [31:0] req_key_x,
   input  logic [31:0] req_key_y,
   input  logic [31:0] req_key_z,
   input  logic [31:0] req_query_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic        rsp_saturated,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [6:0]        key_count_ff;
   logic [15:0]       min_range_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  n_clamp;
   logic [31:0]       qtime_ff;
   logic              inj_ff;
   logic              req_acc;
   logic              wr_en;
   kvl_key_type       wr_key;

   kvl_tok_type       tok [MAX_KEYS+1];

   kvl_key_type       k0_ff, k1_ff;
   logic [31:0]       res_x_ff, res_y_ff, res_z_ff;
   logic              sat_ff;

   logic              rsp_valid_ff;
   logic [31:0]       rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic              rsp_sat_ff;

   // segment setup from the token leaving the last cell
   kvl_tok_type       last_tok;
   kvl_key_type       seg_k0, seg_k1;
   logic signed [32:0] seg_range, seg_diff;
   logic [32:0]       diff_mag;
   logic              do_blend;

   logic              div_start;
   logic [DVD_W-1:0]  div_dividend;
   logic              div_done;
   logic [DVD_W-1:0]  div_quot;
   logic              fneg_ff;
   logic [31:0]       mf_ff;

   // blend loop over components
   logic [1:0]        comp_ff;
   logic              phase_ff;
   logic [63:0]       prod_ff;
   logic              dneg_ff;
   logic [31:0]       v0, v1;
   logic signed [32:0] dval;
   logic [32:0]       dmag;
   logic [49:0]       term;
   logic signed [49:0] bsum;
   logic [31:0]       bclip;
   logic              bsat;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign wr_en     = req_acc && (req_type == REQ_WRITE) && (32'(req_key_slot) < MAX_KEYS);
   assign wr_key    = '{t: req_key_time, x: req_key_x, y: req_key_y, z: req_key_z};
   assign n_clamp   = (32'(key_count_ff) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_ff);

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= 7'd0;
         min_range_ff <= 16'd7;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_COUNT: key_count_ff <= csr_wr_data[6:0];
            CSR_MIN_RANGE: min_range_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // row of key cells; the search token enters cell 0 once per query on a non-empty table
   assign tok[0] = '{valid: inj_ff, first: 1'b1, found: 1'b0, ki: '0, kj: '0};

   for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
      kvl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .idx     (KEY_IDX_W'(g)),
         .wr_en   (wr_en),
         .wr_slot (req_key_slot),
         .wr_key  (wr_key),
         .qtime   (qtime_ff),
         .n       (n_ff),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   assign last_tok  = tok[MAX_KEYS];
   assign seg_k0    = last_tok.ki;
   assign seg_k1    = last_tok.found ? last_tok.kj : last_tok.ki;
   assign seg_range = $signed({seg_k1.t[31], seg_k1.t}) - $signed({seg_k0.t[31], seg_k0.t});
   assign seg_diff  = $signed({qtime_ff[31], qtime_ff}) - $signed({seg_k0.t[31], seg_k0.t});
   assign diff_mag  = seg_diff[32] ? 33'(-seg_diff) : 33'(seg_diff);
   // zero-length segments never divide, also with min_range 0
   assign do_blend  = (n_ff > CNT_W'(1)) && (seg_range > 33'sd0) &&
                      (seg_range >= $signed({17'd0, min_range_ff}));

   assign div_start    = (state_ff == ST_SCAN) && last_tok.valid && do_blend;
   assign div_dividend = {diff_mag, 16'd0};

   kvl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (seg_range[31:0]),
      .done     (div_done),
      .quot     (div_quot)
   );

   // component select and blend arithmetic
   always_comb begin
      case (comp_ff)
         2'd0:    begin v0 = k0_ff.x; v1 = k1_ff.x; end
         2'd1:    begin v0 = k0_ff.y; v1 = k1_ff.y; end
         default: begin v0 = k0_ff.z; v1 = k1_ff.z; end
      endcase
   end

   assign dval = $signed({v1[31], v1}) - $signed({v0[31], v0});
   assign dmag = dval[32] ? 33'(-dval) : 33'(dval);
   assign term = (dneg_ff ^ fneg_ff) ? -{2'b00, prod_ff[63:16]} : {2'b00, prod_ff[63:16]};
   assign bsum = $signed({{18{v0[31]}}, v0}) + $signed(term);

   always_comb begin
      bsat  = 1'b0;
      bclip = bsum[31:0];
      if (bsum > 50'sd2147483647) begin
         bsat  = 1'b1;
         bclip = 32'h7fff_ffff;
      end else if (bsum < -50'sd2147483648) begin
         bsat  = 1'b1;
         bclip = 32'h8000_0000;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_type == REQ_QUERY)) begin
               state_in = (n_clamp == '0) ? ST_OUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_tok.valid) begin
               state_in = do_blend ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (phase_ff && (comp_ff == 2'd2)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inj_ff   <= 1'b0;
         comp_ff  <= 2'd0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inj_ff   <= req_acc && (req_type == REQ_QUERY) && (n_clamp != '0);
         if (state_ff == ST_MUL) begin
            phase_ff <= !phase_ff;
            if (phase_ff) begin
               comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
            end
         end else begin
            comp_ff  <= 2'd0;
            phase_ff <= 1'b0;
         end
      end
   end

   // query datapath
   always_ff @(posedge clock) begin
      if (req_acc && (req_type == REQ_QUERY)) begin
         qtime_ff <= req_query_time;
         n_ff     <= n_clamp;
         res_x_ff <= '0;
         res_y_ff <= '0;
         res_z_ff <= '0;
         sat_ff   <= 1'b0;
      end
      if ((state_ff == ST_SCAN) && last_tok.valid) begin
         k0_ff    <= seg_k0;
         k1_ff    <= seg_k1;
         res_x_ff <= seg_k0.x;
         res_y_ff <= seg_k0.y;
         res_z_ff <= seg_k0.z;
         fneg_ff  <= seg_diff[32];
      end
      // factor clip to signed 32 bits, kept as sign and magnitude
      if (div_done) begin
         if (!fneg_ff && (div_quot > DVD_W'(32'h7fff_ffff))) begin
            mf_ff  <= 32'h7fff_ffff;
            sat_ff <= 1'b1;
         end else if (fneg_ff && (div_quot > DVD_W'(32'h8000_0000))) begin
            mf_ff  <= 32'h8000_0000;
            sat_ff <= 1'b1;
         end else begin
            mf_ff <= div_quot[31:0];
         end
      end
      if (state_ff == ST_MUL) begin
         if (!phase_ff) begin
            prod_ff <= dmag[31:0] * mf_ff;
            dneg_ff <= dval[32];
         end else begin
            case (comp_ff)
               2'd0:    res_x_ff <= bclip;
               2'd1:    res_y_ff <= bclip;
               default: res_z_ff <= bclip;
            endcase
            if (bsat) begin
               sat_ff <= 1'b1;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_x_ff   <= res_x_ff;
         rsp_y_ff   <= res_y_ff;
         rsp_z_ff   <= res_z_ff;
         rsp_sat_ff <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

   // checks
   a_tok_in_scan: assert property (@(posedge clock) disable iff (reset)
      last_tok.valid |-> (state_ff == ST_SCAN))
      else $error("search token left the row outside a scan");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divide finished outside the divide phase");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while a query is in flight");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished query not loaded into the output register");

endmodule

FILE: rtl/kvl_cell.sv
module kvl_cell
   import kvl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [KEY_IDX_W-1:0] idx,
   input  logic                 wr_en,
   input  logic [5:0]           wr_slot,
   input  kvl_key_type          wr_key,
   input  logic [31:0]          qtime,
   input  logic [CNT_W-1:0]     n,
   input  kvl_tok_type          tok_in,
   output kvl_tok_type          tok_out
);

   kvl_key_type key_ff;
   kvl_tok_type tok_ff;
   kvl_tok_type tok_in_n;
   logic        in_use;

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_slot) == 32'(idx))) begin
         key_ff <= wr_key;
      end
   end

   assign in_use = (32'(idx) < 32'(n));

   always_comb begin
      tok_in_n = tok_in;
      tok_in_n.first = 1'b0;
      if (tok_in.first) begin
         tok_in_n.ki = key_ff;
         tok_in_n.found = 1'b0;
      end else if (!tok_in.found) begin
         if (in_use && !($signed(qtime) < $signed(key_ff.t))) begin
            tok_in_n.ki = key_ff;
         end else begin
            tok_in_n.found = 1'b1;
            tok_in_n.kj = in_use ? key_ff : tok_in.ki;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: rtl/kvl_divider.sv
module kvl_divider
   import kvl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [DVD_W-1:0] quot
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [31:0]          rem_ff;
   logic [DVD_W-1:0]     dvd_ff;
   logic [DVD_W-1:0]     q_ff;
   logic [32:0]          shifted;
   logic                 ge;
   logic [32:0]          diff;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = (shifted >= {1'b0, divisor});
   assign diff    = shifted - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (32'(cnt_ff) == DVD_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         dvd_ff <= dividend;
         q_ff   <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= ge ? diff[31:0] : shifted[31:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         q_ff   <= {q_ff[DVD_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import kvl_pkg::*;

   // one request word as the sender holds it
   typedef struct {
      logic        kind;
      logic [5:0]  slot;
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] qt;
   } req_word_type;

   // one sampled vector as the response carries it
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        sat;
   } sample_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CSR} row_kind_type;

   // one line of the directed table
   typedef struct {
      row_kind_type kind;
      req_word_type w;
      logic [1:0]   csr_idx;
      logic [15:0]  csr_val;
      bit           typed;
      sample_type   res;
   } row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 130;
   localparam int ITEM_TARGET    = 1700;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [5:0]  req_key_slot;
   logic [31:0] req_key_time;
   logic [31:0] req_key_x;
   logic [31:0] req_key_y;
   logic [31:0] req_key_z;
   logic [31:0] req_query_time;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic        rsp_saturated;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wr_data;

   keyframe_vec3_lerp DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key_slot(req_key_slot),
      .req_key_time(req_key_time),
      .req_key_x(req_key_x),
      .req_key_y(req_key_y),
      .req_key_z(req_key_z),
      .req_query_time(req_query_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z),
      .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // shadow copy of the key table and registers
   logic [31:0] key_time_tab [MAX_KEYS];
   logic [31:0] key_x_tab [MAX_KEYS];
   logic [31:0] key_y_tab [MAX_KEYS];
   logic [31:0] key_z_tab [MAX_KEYS];
   bit          key_written [MAX_KEYS];
   int unsigned shadow_key_count;
   int unsigned shadow_min_range;

   sample_type  pending_samples [$];
   row_type     directed_rows [$];
   int          mismatch_count;
   int          idle_cycles;
   int          items_sent;
   int          burst_left;
   bit          gaps_on;
   int          stall_mode;
   int          stall_mode_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // clip to signed 32 bits, flag any clip
   function automatic longint clip_s32(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // v0 + (v1 - v0) * f / 2^16, product truncated toward zero
   function automatic longint blend_comp(input longint v0, input longint v1,
                                         input longint f, inout bit sat);
      longint     d;
      bit [63:0]  md;
      bit [63:0]  mf;
      bit [63:0]  mag;
      longint     term;
      d   = v1 - v0;
      md  = (d < 0) ? -d : d;
      mf  = (f < 0) ? -f : f;
      mag = (md * mf) >> 16;
      term = ((d < 0) != (f < 0)) ? -longint'(mag) : longint'(mag);
      return clip_s32(v0 + term, sat);
   endfunction

   // expected response for a query against the shadow table
   function automatic sample_type predict_sample(input logic [31:0] qt);
      int unsigned n;
      int unsigned i;
      int unsigned j;
      longint      t;
      longint      t0;
      longint      t1;
      longint      seg;
      longint      fac;
      longint      rx;
      longint      ry;
      longint      rz;
      bit          sat;
      sample_type  r;
      sat = 1'b0;
      n = (shadow_key_count > MAX_KEYS) ? MAX_KEYS : shadow_key_count;
      t = longint'($signed(qt));
      rx = 0;
      ry = 0;
      rz = 0;
      if (n != 0) begin
         i = 0;
         // first segment whose end time is past the query
         while (i + 1 < n && !(t < longint'($signed(key_time_tab[i + 1]))))
            i++;
         j = (i + 1 < n) ? i + 1 : i;
         rx = longint'($signed(key_x_tab[i]));
         ry = longint'($signed(key_y_tab[i]));
         rz = longint'($signed(key_z_tab[i]));
         t0 = longint'($signed(key_time_tab[i]));
         t1 = longint'($signed(key_time_tab[j]));
         seg = t1 - t0;
         if (n > 1 && seg > 0 && seg >= longint'(shadow_min_range)) begin
            // longint division truncates toward zero
            fac = clip_s32(((t - t0) * 65536) / seg, sat);
            rx = blend_comp(rx, longint'($signed(key_x_tab[j])), fac, sat);
            ry = blend_comp(ry, longint'($signed(key_y_tab[j])), fac, sat);
            rz = blend_comp(rz, longint'($signed(key_z_tab[j])), fac, sat);
         end
      end
      r.x = rx[31:0];
      r.y = ry[31:0];
      r.z = rz[31:0];
      r.sat = sat;
      return r;
   endfunction

   // drive one word, wait for it to be taken, then update the shadow
   task automatic send_word(input req_word_type w, input bit typed, input sample_type res);
      req_valid      <= 1'b1;
      req_type       <= w.kind;
      req_key_slot   <= w.slot;
      req_key_time   <= w.t;
      req_key_x      <= w.x;
      req_key_y      <= w.y;
      req_key_z      <= w.z;
      req_query_time <= w.qt;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (w.kind == REQ_WRITE) begin
         key_time_tab[w.slot] = w.t;
         key_x_tab[w.slot]    = w.x;
         key_y_tab[w.slot]    = w.y;
         key_z_tab[w.slot]    = w.z;
         key_written[w.slot]  = 1'b1;
      end else begin
         pending_samples.insert(pending_samples.size(), typed ? res : predict_sample(w.qt));
      end
      items_sent++;
      // bursts with random gaps, some stretches back to back
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 5) == 0)
            gaps_on = !gaps_on;
      end
   endtask

   // drain all responses, then let trailing writes settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_KEY_COUNT)
         shadow_key_count = val[6:0];
      else if (idx == CSR_MIN_RANGE)
         shadow_min_range = val;
   endtask

   function automatic req_word_type key_word(input logic [5:0] slot, input logic [31:0] t,
                                             input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z);
      req_word_type w;
      w.kind = REQ_WRITE;
      w.slot = slot;
      w.t = t;
      w.x = x;
      w.y = y;
      w.z = z;
      w.qt = $urandom();
      return w;
   endfunction

   function automatic req_word_type query_word(input logic [31:0] qt);
      req_word_type w;
      w = key_word(6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
      w.kind = REQ_QUERY;
      w.qt = qt;
      return w;
   endfunction

   // directed table builders
   task automatic add_key(input logic [5:0] slot, input logic [31:0] t, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z);
      row_type r;
      r.kind = ROW_WRITE;
      r.w = key_word(slot, t, x, y, z);
      r.typed = 1'b0;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   task automatic add_query(input logic [31:0] qt, input bit typed, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
      row_type r;
      r.kind = ROW_QUERY;
      r.w = query_word(qt);
      r.typed = typed;
      r.res.x = x;
      r.res.y = y;
      r.res.z = z;
      r.res.sat = 1'b0;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   task automatic add_csr(input logic [1:0] idx, input logic [15:0] val);
      row_type r;
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      r.typed = 1'b0;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // sorted key times: mostly moderate gaps, some short, some huge
   function automatic logic [31:0] next_key_time(input longint prev);
      longint step;
      longint nt;
      case ($urandom_range(0, 9))
         0, 1:    step = $urandom_range(0, 10);
         2:       step = longint'($urandom_range(0, 32'h7fff_ffff)) * 2;
         default: step = $urandom_range(1, 32'h0004_0000);
      endcase
      nt = prev + step;
      if (nt > 64'sd2147483647)
         nt = 64'sd2147483647;
      return nt[31:0];
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   // query times aimed at the stored segments
   function automatic logic [31:0] pick_query_time();
      int unsigned n;
      int unsigned k;
      longint      lo;
      longint      hi;
      n = (shadow_key_count == 0) ? 1 : shadow_key_count;
      k = $urandom_range(0, n - 1);
      lo = longint'($signed(key_time_tab[k]));
      hi = longint'($signed(key_time_tab[(k + 1 < n) ? k + 1 : k]));
      case ($urandom_range(0, 9))
         0: return key_time_tab[k];
         1: return $urandom();
         2: return key_time_tab[0] - $urandom_range(1, 32'h0002_0000);
         3: return key_time_tab[n - 1] + $urandom_range(0, 32'h0002_0000);
         default: begin
            if (hi > lo)
               return 32'(lo + longint'($urandom_range(0, 32'hffff_ffff)) % (hi - lo));
            return key_time_tab[k] + $urandom_range(0, 16);
         end
      endcase
   endfunction

   // main stimulus
   initial begin
      row_type     r;
      sample_type  none;
      int unsigned n;
      int unsigned nq;
      longint      tprev;
      logic [15:0] mr;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_WRITE;
      req_key_slot   <= '0;
      req_key_time   <= '0;
      req_key_x      <= '0;
      req_key_y      <= '0;
      req_key_z      <= '0;
      req_query_time <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_KEY_COUNT;
      csr_wr_data    <= '0;
      mismatch_count = 0;
      items_sent     = 0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      shadow_key_count = 0;
      shadow_min_range = 7;
      none = '{x: '0, y: '0, z: '0, sat: 1'b0};
      foreach (key_written[k])
         key_written[k] = 1'b0;

      // empty table returns a zero vector
      add_query(32'h0000_0000, 1'b1, '0, '0, '0);
      add_query(32'h7fff_ffff, 1'b1, '0, '0, '0);
      add_query(32'h8000_0000, 1'b1, '0, '0, '0);
      add_key(6'd0, 32'h0000_0000, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
      add_key(6'd1, 32'h0000_0010, 32'h7fff_ffff, 32'hffff_0000, 32'h0000_0000);
      add_key(6'd2, 32'h0001_0000, 32'h0000_1234, 32'h0002_0000, 32'hffff_ffff);
      add_key(6'd3, 32'h0001_0003, 32'h0005_0000, 32'h8000_0000, 32'h0000_0001);
      // single key returns key0 as stored
      add_csr(CSR_KEY_COUNT, 16'd1);
      add_query(32'h8000_0000, 1'b1, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
      add_query(32'h7fff_ffff, 1'b1, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
      add_csr(CSR_KEY_COUNT, 16'd4);
      // short segment returns key0 of the segment
      add_query(32'h0001_0001, 1'b1, 32'h0000_1234, 32'h0002_0000, 32'hffff_ffff);
      // past the last key returns the last key
      add_query(32'h7fff_ffff, 1'b1, 32'h0005_0000, 32'h8000_0000, 32'h0000_0001);
      add_query(32'h0000_0008, 1'b0, '0, '0, '0);
      add_query(32'hffff_0000, 1'b0, '0, '0, '0);
      add_query(32'h8000_0000, 1'b0, '0, '0, '0);
      add_query(32'h0000_8000, 1'b0, '0, '0, '0);
      // zero threshold lets the short segment blend
      add_csr(CSR_MIN_RANGE, 16'd0);
      add_query(32'h0001_0002, 1'b0, '0, '0, '0);
      add_query(32'h7fff_ffff, 1'b1, 32'h0005_0000, 32'h8000_0000, 32'h0000_0001);
      add_csr(CSR_MIN_RANGE, 16'hffff);
      add_query(32'h0000_0008, 1'b1, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
      add_query(32'h0000_8000, 1'b0, '0, '0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         case (r.kind)
            ROW_CSR: begin
               wait_idle();
               write_csr(r.csr_idx, r.csr_val);
            end
            default: send_word(r.w, r.typed, r.res);
         endcase
      end

      // random phases: a sorted table, a setting, then queries and stray writes
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0:       n = 0;
            1:       n = 1;
            2:       n = 2;
            3:       n = MAX_KEYS;
            default: n = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 5))
            0:       mr = 16'd0;
            1:       mr = 16'hffff;
            2:       mr = 16'd7;
            3:       mr = 16'($urandom_range(0, 16));
            default: mr = 16'($urandom());
         endcase
         if ($urandom_range(0, 9) < 7) begin
            tprev = longint'($signed(rand_value())) / ($urandom_range(0, 3) == 0 ? 1 : 4096);
            for (int k = 0; k < n; k++) begin
               send_word(key_word(6'(k), tprev[31:0], rand_value(), rand_value(), rand_value()),
                         1'b0, none);
               tprev = longint'($signed(next_key_time(tprev)));
            end
         end
         // never let the table read an entry that was not written
         for (int k = 0; k < n; k++)
            if (!key_written[k])
               send_word(key_word(6'(k), $urandom(), rand_value(), rand_value(), rand_value()),
                         1'b0, none);
         wait_idle();
         write_csr(CSR_KEY_COUNT, 16'(n));
         write_csr(CSR_MIN_RANGE, mr);
         nq = $urandom_range(10, 40);
         for (int k = 0; k < nq; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(key_word(6'($urandom()), $urandom(), rand_value(), rand_value(),
                                  rand_value()), 1'b0, none);
            else
               send_word(query_word(pick_query_time()), 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver stall pattern, response check and watchdog
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rsp_stall       <= 1'b0;
         idle_cycles     = 0;
         stall_mode      = 0;
         stall_mode_left = 0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(50, 600);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) != 0);
            default: rsp_stall <= 1'b0;
         endcase

         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               $display("%0t: response word with nothing expected: %h %h %h %b", $time,
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
               mismatch_count++;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_out_x !== want.x) begin
                  $display("%0t: out_x expected %h actual %h", $time, want.x, rsp_out_x);
                  mismatch_count++;
               end
               if (rsp_out_y !== want.y) begin
                  $display("%0t: out_y expected %h actual %h", $time, want.y, rsp_out_y);
                  mismatch_count++;
               end
               if (rsp_out_z !== want.z) begin
                  $display("%0t: out_z expected %h actual %h", $time, want.z, rsp_out_z);
                  mismatch_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $display("%0t: saturated expected %b actual %b", $time, want.sat,
                           rsp_saturated);
                  mismatch_count++;
               end
            end
         end

         // anything taken on either channel or the csr port resets the count
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
